FILE: hw/rtl/arst_pkg.sv
// shared types, codes and helpers for the address range symbol table
package arst_pkg;

    localparam int TABLE_DEPTH_DEF = 2048;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_FULL        = 3'd1,
        ST_ZERO_EXTENT = 3'd2,
        ST_HIT         = 3'd3,
        ST_MISS        = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_INSERT,
        FSM_LOOKUP,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic [0:0]  opcode;
        logic [63:0] address;
        logic [31:0] extent;
        logic [15:0] name_offset;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] found_name;
        logic [31:0] offset_in_range;
    } out_beat_t;

    typedef struct packed {
        logic [63:0] start;
        logic [31:0] extent;
        logic [15:0] name;
    } ent_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic ins_en;
        ent_t key;
    } cell_ctl_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] name;
        logic [31:0] offs;
    } hit_t;

    // registered levels of a four-way reduction tree over n leaves
    function automatic int tree_levels(input int n);
        int levels;
        int span;
        levels = 0;
        span   = 1;
        while (span < n) begin
            span   = span * 4;
            levels = levels + 1;
        end
        if (levels == 0) begin
            levels = 1;
        end
        return levels;
    endfunction

endpackage

FILE: hw/rtl/arst_cell.sv
// one table cell: holds an entry, shifts on insert, flags the covering entry on lookup
module arst_cell (
    input  logic                 aclk,
    input  arst_pkg::cell_ctl_t  ctl,
    input  logic                 valid,
    input  arst_pkg::ent_t       prev_ent,
    input  logic                 prev_move,
    input  logic                 le_next,
    output arst_pkg::ent_t       ent,
    output logic                 move,
    output logic                 le,
    output arst_pkg::hit_t       hit
);

    arst_pkg::ent_t ent_reg;
    arst_pkg::ent_t ent_next;
    logic           le_comb;
    logic [63:0]    diff;
    logic           le_reg;
    logic           hi_zero_reg;
    logic [31:0]    diff_lo_reg;
    arst_pkg::hit_t hit_reg;
    arst_pkg::hit_t hit_next;

    assign le_comb = valid && (ent_reg.start <= ctl.key.start);
    // cells past the insert point (and empty ones) move up by one
    assign move    = !le_comb;
    assign diff    = ctl.key.start - ent_reg.start;

    always_comb begin
        ent_next = ent_reg;
        if (ctl.ins_en && move) begin
            ent_next = prev_move ? prev_ent : ctl.key;
        end
    end

    always_comb begin
        hit_next = '0;
        // last entry at or below the key, and the key inside its extent
        if (le_reg && !le_next && hi_zero_reg && (diff_lo_reg < ent_reg.extent)) begin
            hit_next.hit  = 1'b1;
            hit_next.name = ent_reg.name;
            hit_next.offs = diff_lo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg     <= ent_next;
        le_reg      <= le_comb;
        hi_zero_reg <= (diff[63:32] == 32'd0);
        diff_lo_reg <= diff[31:0];
        hit_reg     <= hit_next;
    end

    assign ent = ent_reg;
    assign le  = le_reg;
    assign hit = hit_reg;

endmodule

FILE: hw/rtl/arst_or_tree.sv
// registered four-way or tree that gathers the single flagged cell result
module arst_or_tree #(
    parameter int NUM_LEAVES = arst_pkg::TABLE_DEPTH_DEF
) (
    input  logic           aclk,
    input  arst_pkg::hit_t leaf [NUM_LEAVES],
    output arst_pkg::hit_t root
);

    localparam int LEVELS = arst_pkg::tree_levels(NUM_LEAVES);
    localparam int PAD    = 4 ** LEVELS;
    localparam int INNER  = (PAD - 1) / 3;

    arst_pkg::hit_t node_reg [INNER];

    // heap order: node k has children 4k+1 .. 4k+4, leaves follow the inner nodes
    for (genvar k = 0; k < INNER; k++) begin : g_node
        arst_pkg::hit_t kid [4];
        for (genvar j = 0; j < 4; j++) begin : g_kid
            localparam int C = 4 * k + 1 + j;
            if (C < INNER) begin : g_inner
                assign kid[j] = node_reg[C];
            end else if (C - INNER < NUM_LEAVES) begin : g_leaf
                assign kid[j] = leaf[C - INNER];
            end else begin : g_pad
                assign kid[j] = '0;
            end
        end
        always_ff @(posedge aclk) begin
            node_reg[k] <= arst_pkg::hit_t'(kid[0] | kid[1] | kid[2] | kid[3]);
        end
    end

    assign root = node_reg[0];

endmodule

FILE: hw/rtl/address_range_symbol_table.sv
// Address range symbol table: a sorted row of entry cells with insert and lookup.
// Input channel s_valid/s_ready/s_data carries one command beat: opcode insert
// (address = range start, extent, name_offset) or lookup (address = probe).
// Output channel m_valid/m_ready/m_data returns exactly one result beat per command.
// Entries live in a row of cells, one entry each, kept sorted by start address;
// an insert shifts every cell past the insert point up by one, all in the same cycle.
// Insert: the result goes to the result register, then the output register. Lookup: one
// compare stage, one flag stage in every cell, the registered four-way or tree that brings
// the covering entry to the root, then the result register and the output register.
// One command is worked on at a time; s_ready is high while the controller is idle,
// and a finished result waits in the output register, so the next command is taken
// while m_valid is still high. If the receiver stalls with a result already waiting,
// the next result is held until the output register frees, and input stays closed.
// Reset (aresetn low, synchronous) empties the table and drops any waiting result;
// entry contents are not cleared, only the entry count.
module address_range_symbol_table #(
    parameter int TABLE_DEPTH = arst_pkg::TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  arst_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output arst_pkg::out_beat_t m_data
);

    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LAT    = 2 + arst_pkg::tree_levels(TABLE_DEPTH);
    localparam int WAIT_W = $clog2(LAT + 1);

    arst_pkg::fsm_t      state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    arst_pkg::in_beat_t  key_reg, key_next;
    arst_pkg::out_beat_t res_reg, res_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic                m_valid_reg, m_valid_next;
    arst_pkg::out_beat_t m_data_reg, m_data_next;
    logic                ins_ok;
    logic                ins_en;

    arst_pkg::cell_ctl_t ctl;
    arst_pkg::ent_t      cell_ent  [TABLE_DEPTH];
    logic                cell_move [TABLE_DEPTH];
    logic                cell_le   [TABLE_DEPTH];
    logic                cell_val  [TABLE_DEPTH];
    arst_pkg::hit_t      cell_hit  [TABLE_DEPTH];
    arst_pkg::hit_t      root;

    assign ctl.ins_en     = ins_en;
    assign ctl.key.start  = key_reg.address;
    assign ctl.key.extent = key_reg.extent;
    assign ctl.key.name   = key_reg.name_offset;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        assign cell_val[i] = (count_reg > CNT_W'(i));
        if (i == 0) begin : g_first
            arst_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .valid     (cell_val[i]),
                .prev_ent  (ctl.key),
                .prev_move (1'b0),
                .le_next   (cell_le[i + 1]),
                .ent       (cell_ent[i]),
                .move      (cell_move[i]),
                .le        (cell_le[i]),
                .hit       (cell_hit[i])
            );
        end else if (i == TABLE_DEPTH - 1) begin : g_last
            arst_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .valid     (cell_val[i]),
                .prev_ent  (cell_ent[i - 1]),
                .prev_move (cell_move[i - 1]),
                .le_next   (1'b0),
                .ent       (cell_ent[i]),
                .move      (cell_move[i]),
                .le        (cell_le[i]),
                .hit       (cell_hit[i])
            );
        end else begin : g_mid
            arst_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .valid     (cell_val[i]),
                .prev_ent  (cell_ent[i - 1]),
                .prev_move (cell_move[i - 1]),
                .le_next   (cell_le[i + 1]),
                .ent       (cell_ent[i]),
                .move      (cell_move[i]),
                .le        (cell_le[i]),
                .hit       (cell_hit[i])
            );
        end
    end

    arst_or_tree #(
        .NUM_LEAVES (TABLE_DEPTH)
    ) u_or_tree (
        .aclk (aclk),
        .leaf (cell_hit),
        .root (root)
    );

    assign ins_ok = (key_reg.extent != 32'd0) && (count_reg != CNT_W'(TABLE_DEPTH));

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        res_next     = res_reg;
        wait_next    = wait_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ins_en       = 1'b0;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            arst_pkg::FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    key_next  = s_data;
                    wait_next = '0;
                    state_next = (s_data.opcode == arst_pkg::OP_INSERT) ?
                                 arst_pkg::FSM_INSERT : arst_pkg::FSM_LOOKUP;
                end
            end
            arst_pkg::FSM_INSERT: begin
                res_next = '0;
                if (key_reg.extent == 32'd0) begin
                    res_next.status = arst_pkg::ST_ZERO_EXTENT;
                end else if (!ins_ok) begin
                    res_next.status = arst_pkg::ST_FULL;
                end else begin
                    res_next.status = arst_pkg::ST_INSERTED;
                    ins_en          = 1'b1;
                    count_next      = count_reg + 1'b1;
                end
                state_next = arst_pkg::FSM_DONE;
            end
            arst_pkg::FSM_LOOKUP: begin
                if (wait_reg == WAIT_W'(LAT)) begin
                    res_next = '0;
                    if (root.hit) begin
                        res_next.status          = arst_pkg::ST_HIT;
                        res_next.found_name      = root.name;
                        res_next.offset_in_range = root.offs;
                    end else begin
                        res_next.status = arst_pkg::ST_MISS;
                    end
                    state_next = arst_pkg::FSM_DONE;
                end else begin
                    wait_next = wait_reg + 1'b1;
                end
            end
            arst_pkg::FSM_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = arst_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = arst_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= arst_pkg::FSM_IDLE;
            count_reg   <= '0;
            wait_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wait_reg    <= wait_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_insert_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted insert did not bump entry count");

    a_hit_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == arst_pkg::FSM_LOOKUP && wait_reg == WAIT_W'(LAT) && root.hit)
        |-> count_reg != '0)
        else $error("lookup hit with an empty table");

    a_no_shift_on_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == arst_pkg::FSM_LOOKUP) |-> !ins_en)
        else $error("cells shifted during a lookup");
`endif

endmodule
